// ----- src/hcd_pkg.sv -----
// Shared constants and register codes for the haptic compass drive.
`timescale 1ns / 1ps

package hcd_pkg;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_BASE_STRENGTH = 2'd0,
      CSR_FULL_DUTY     = 2'd1
   } csr_index_type;

   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 16;
   localparam int BASE_W        = 16;
   localparam int DUTY_W        = 8;
   localparam int QUO_W         = 8;

   localparam logic [BASE_W-1:0] BASE_STRENGTH_RESET = 16'd15000;
   localparam logic [DUTY_W-1:0] FULL_DUTY_RESET     = 8'd240;

   // Root lanes: total field and y/z plane
   localparam int ROOT_LANES = 2;
   localparam int ROOT_ALL   = 0;
   localparam int ROOT_YZ    = 1;

   // Divider lanes
   localparam int DIV_LANES   = 3;
   localparam int LANE_PERIOD = 0;
   localparam int LANE_DUTY_Y = 1;
   localparam int LANE_DUTY_Z = 2;

endpackage

// ----- src/haptic_compass_drive.sv -----
// Top level: magnetometer sample to buzzer period and duties.
//
//   port group  direction  carries
//   req_*       in         one sample: mag_x, mag_y, mag_z
//   rsp_*       out        period_ms, duty_y, duty_z
//   csr_*       in         register index and write data
//
// One sample enters per cycle unless a stall reaches the input register;
// it passes the input register, square stage, SAMPLE_BITS root cells,
// divisor prep and eight quotient cells. Every cell holds its item until the
// next one frees up, so a stall at rsp_ready backs up cell by cell and empty
// cells keep taking samples. An all-zero sample is dropped at the input
// register. Reset clears the cell valids and loads the register defaults.
`timescale 1ns / 1ps

module haptic_compass_drive #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [SAMPLE_BITS-1:0]      req_mag_x,
   input  logic signed [SAMPLE_BITS-1:0]      req_mag_y,
   input  logic signed [SAMPLE_BITS-1:0]      req_mag_z,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [hcd_pkg::QUO_W-1:0]          rsp_period_ms,
   output logic [hcd_pkg::QUO_W-1:0]          rsp_duty_y,
   output logic [hcd_pkg::QUO_W-1:0]          rsp_duty_z,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [hcd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [hcd_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int S      = SAMPLE_BITS;
   localparam int SQ_W   = 2 * S;
   localparam int C_W    = S - 1;
   localparam int SIDE_W = 2 * C_W;
   localparam int REM_W  = S + 2;
   localparam int NUM_W  = (hcd_pkg::BASE_W > S + 7) ? hcd_pkg::BASE_W : S + 7;
   localparam int DIV_W  = S + 1;
   localparam int SAT_W  = NUM_W + 2;
   localparam int NQ     = hcd_pkg::QUO_W;

   // ---------------- configuration registers ----------------
   logic [hcd_pkg::BASE_W-1:0] base_ff;
   logic [hcd_pkg::DUTY_W-1:0] full_duty_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= hcd_pkg::BASE_STRENGTH_RESET;
         full_duty_ff <= hcd_pkg::FULL_DUTY_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            hcd_pkg::CSR_BASE_STRENGTH: base_ff <= csr_data[hcd_pkg::BASE_W-1:0];
            hcd_pkg::CSR_FULL_DUTY:     full_duty_ff <= csr_data[hcd_pkg::DUTY_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- input register ----------------
   logic                  in_valid_ff;
   logic                  in_ready;
   logic signed [S-1:0]   x_ff, y_ff, z_ff;
   logic                  sample_zero;
   logic                  sq_ready;

   assign sample_zero = (req_mag_x == '0) && (req_mag_y == '0) && (req_mag_z == '0);
   assign in_ready    = !in_valid_ff || sq_ready;
   assign req_ready   = in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         // drop an all-zero sample here
         in_valid_ff <= req_valid && !sample_zero;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_valid) begin
         x_ff <= req_mag_x;
         y_ff <= req_mag_y;
         z_ff <= req_mag_z;
      end
   end

   // ---------------- square stage ----------------
   logic                  sq_valid_ff;
   logic [SQ_W-1:0]       all2_ff, all2_in;
   logic [SQ_W-1:0]       yz2_ff, yz2_in;
   logic [C_W-1:0]        cy_ff, cy_in, cz_ff, cz_in;
   logic signed [SQ_W-1:0] x_wide, y_wide, z_wide;
   logic [SQ_W-1:0]       xx, yy, zz;
   logic                  rt_first_ready;

   assign x_wide   = SQ_W'(x_ff);
   assign y_wide   = SQ_W'(y_ff);
   assign z_wide   = SQ_W'(z_ff);
   assign xx       = x_wide * x_wide;
   assign yy       = y_wide * y_wide;
   assign zz       = z_wide * z_wide;
   assign yz2_in   = yy + zz;
   assign all2_in  = yy + zz + xx;
   // negative components drive no duty
   assign cy_in    = (y_ff > 0) ? y_ff[C_W-1:0] : '0;
   assign cz_in    = (z_ff > 0) ? z_ff[C_W-1:0] : '0;
   assign sq_ready = !sq_valid_ff || rt_first_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else if (sq_ready) begin
         sq_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (sq_ready && in_valid_ff) begin
         all2_ff <= all2_in;
         yz2_ff  <= yz2_in;
         cy_ff   <= cy_in;
         cz_ff   <= cz_in;
      end
   end

   // ---------------- root chain ----------------
   logic [S:0]                                         rt_valid;
   logic [S:0]                                         rt_ready;
   logic [hcd_pkg::ROOT_LANES-1:0][SQ_W-1:0]           rt_rad  [0:S];
   logic [hcd_pkg::ROOT_LANES-1:0][REM_W-1:0]          rt_rem  [0:S];
   logic [hcd_pkg::ROOT_LANES-1:0][S-1:0]              rt_root [0:S];
   logic [SIDE_W-1:0]                                  rt_side [0:S];

   assign rt_valid[0]                   = sq_valid_ff;
   assign rt_first_ready                = rt_ready[0];
   assign rt_rad[0][hcd_pkg::ROOT_ALL]  = all2_ff;
   assign rt_rad[0][hcd_pkg::ROOT_YZ]   = yz2_ff;
   assign rt_rem[0]                     = '0;
   assign rt_root[0]                    = '0;
   assign rt_side[0]                    = {cy_ff, cz_ff};

   for (genvar k = 0; k < S; k++) begin : g_root
      hcd_root_cell #(
         .RAD_W  (SQ_W),
         .ROOT_W (S),
         .SIDE_W (SIDE_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (rt_valid[k]),
         .up_ready (rt_ready[k]),
         .up_rad   (rt_rad[k]),
         .up_rem   (rt_rem[k]),
         .up_root  (rt_root[k]),
         .up_side  (rt_side[k]),
         .dn_valid (rt_valid[k+1]),
         .dn_ready (rt_ready[k+1]),
         .dn_rad   (rt_rad[k+1]),
         .dn_rem   (rt_rem[k+1]),
         .dn_root  (rt_root[k+1]),
         .dn_side  (rt_side[k+1])
      );
   end

   // ---------------- divisor prep ----------------
   logic                                         prep_valid_ff;
   logic                                         prep_ready;
   logic [hcd_pkg::DIV_LANES-1:0][NUM_W-1:0]     num_ff, num_in;
   logic [hcd_pkg::DIV_LANES-1:0][DIV_W-1:0]     den_ff, den_in;
   logic [DIV_W-1:0]                             period_den;
   logic [S-1:0]                                 root_all, root_yz;
   logic [C_W-1:0]                               cy, cz;
   logic                                         period_sat;
   logic                                         yz_zero;
   logic                                         dv_first_ready;

   assign root_all   = rt_root[S][hcd_pkg::ROOT_ALL];
   assign root_yz    = rt_root[S][hcd_pkg::ROOT_YZ];
   assign cy         = rt_side[S][SIDE_W-1:C_W];
   assign cz         = rt_side[S][C_W-1:0];
   assign period_den = DIV_W'(root_all) + DIV_W'(1);
   // quotient above the eight-bit range saturates
   assign period_sat = SAT_W'(base_ff) >= (SAT_W'(period_den) << NQ);
   assign yz_zero    = (root_yz == '0);
   assign prep_ready = !prep_valid_ff || dv_first_ready;
   assign rt_ready[S] = prep_ready;

   always_comb begin
      if (period_sat) begin
         num_in[hcd_pkg::LANE_PERIOD] = NUM_W'({NQ{1'b1}});
         den_in[hcd_pkg::LANE_PERIOD] = DIV_W'(1);
      end else begin
         num_in[hcd_pkg::LANE_PERIOD] = NUM_W'(base_ff);
         den_in[hcd_pkg::LANE_PERIOD] = period_den;
      end
      if (yz_zero) begin
         num_in[hcd_pkg::LANE_DUTY_Y] = '0;
         num_in[hcd_pkg::LANE_DUTY_Z] = '0;
         den_in[hcd_pkg::LANE_DUTY_Y] = DIV_W'(1);
         den_in[hcd_pkg::LANE_DUTY_Z] = DIV_W'(1);
      end else begin
         num_in[hcd_pkg::LANE_DUTY_Y] = NUM_W'(full_duty_ff) * NUM_W'(cy);
         num_in[hcd_pkg::LANE_DUTY_Z] = NUM_W'(full_duty_ff) * NUM_W'(cz);
         den_in[hcd_pkg::LANE_DUTY_Y] = DIV_W'(root_yz);
         den_in[hcd_pkg::LANE_DUTY_Z] = DIV_W'(root_yz);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (prep_ready) begin
         prep_valid_ff <= rt_valid[S];
      end
   end

   always_ff @(posedge clock) begin
      if (prep_ready && rt_valid[S]) begin
         num_ff <= num_in;
         den_ff <= den_in;
      end
   end

   // ---------------- divider chain ----------------
   logic [NQ:0]                                       dv_valid;
   logic [NQ:0]                                       dv_ready;
   logic [hcd_pkg::DIV_LANES-1:0][NUM_W-1:0]          dv_rem [0:NQ];
   logic [hcd_pkg::DIV_LANES-1:0][DIV_W-1:0]          dv_div [0:NQ];
   logic [hcd_pkg::DIV_LANES-1:0][NQ-1:0]             dv_quo [0:NQ];

   assign dv_valid[0]    = prep_valid_ff;
   assign dv_first_ready = dv_ready[0];
   assign dv_rem[0]      = num_ff;
   assign dv_div[0]      = den_ff;
   assign dv_quo[0]      = '0;

   for (genvar k = 0; k < NQ; k++) begin : g_div
      hcd_div_cell #(
         .NUM_W (NUM_W),
         .DIV_W (DIV_W),
         .BIT   (NQ - 1 - k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (dv_valid[k]),
         .up_ready (dv_ready[k]),
         .up_rem   (dv_rem[k]),
         .up_div   (dv_div[k]),
         .up_quo   (dv_quo[k]),
         .dn_valid (dv_valid[k+1]),
         .dn_ready (dv_ready[k+1]),
         .dn_rem   (dv_rem[k+1]),
         .dn_div   (dv_div[k+1]),
         .dn_quo   (dv_quo[k+1])
      );
   end

   // the last quotient cell is the output register
   assign rsp_valid     = dv_valid[NQ];
   assign dv_ready[NQ]  = rsp_ready;
   assign rsp_period_ms = dv_quo[NQ][hcd_pkg::LANE_PERIOD];
   assign rsp_duty_y    = dv_quo[NQ][hcd_pkg::LANE_DUTY_Y];
   assign rsp_duty_z    = dv_quo[NQ][hcd_pkg::LANE_DUTY_Z];

   // ---------------- assertions ----------------
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_load_nonzero: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !sample_zero |=> in_valid_ff)
      else $error("nonzero sample not captured");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && sample_zero |=> !in_valid_ff)
      else $error("all-zero sample entered the pipeline");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      prep_valid_ff |-> (den_ff[hcd_pkg::LANE_PERIOD] != '0)
                     && (den_ff[hcd_pkg::LANE_DUTY_Y] != '0)
                     && (den_ff[hcd_pkg::LANE_DUTY_Z] != '0))
      else $error("zero divisor entered the divider chain");

endmodule

// ----- src/hcd_root_cell.sv -----
// One digit step of the two-lane integer square root chain.
`timescale 1ns / 1ps

module hcd_root_cell #(
   parameter int RAD_W  = 24,
   parameter int ROOT_W = 12,
   parameter int SIDE_W = 22
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           up_valid,
   output logic                                           up_ready,
   input  logic [hcd_pkg::ROOT_LANES-1:0][RAD_W-1:0]      up_rad,
   input  logic [hcd_pkg::ROOT_LANES-1:0][ROOT_W+1:0]     up_rem,
   input  logic [hcd_pkg::ROOT_LANES-1:0][ROOT_W-1:0]     up_root,
   input  logic [SIDE_W-1:0]                              up_side,
   output logic                                           dn_valid,
   input  logic                                           dn_ready,
   output logic [hcd_pkg::ROOT_LANES-1:0][RAD_W-1:0]      dn_rad,
   output logic [hcd_pkg::ROOT_LANES-1:0][ROOT_W+1:0]     dn_rem,
   output logic [hcd_pkg::ROOT_LANES-1:0][ROOT_W-1:0]     dn_root,
   output logic [SIDE_W-1:0]                              dn_side
);

   localparam int REM_W = ROOT_W + 2;
   localparam int TR_W  = REM_W + 2;

   logic                                        valid_ff;
   logic [hcd_pkg::ROOT_LANES-1:0][RAD_W-1:0]   rad_ff, rad_in;
   logic [hcd_pkg::ROOT_LANES-1:0][REM_W-1:0]   rem_ff, rem_in;
   logic [hcd_pkg::ROOT_LANES-1:0][ROOT_W-1:0]  root_ff, root_in;
   logic [SIDE_W-1:0]                           side_ff;
   logic [hcd_pkg::ROOT_LANES-1:0][TR_W-1:0]    trial;
   logic [hcd_pkg::ROOT_LANES-1:0][TR_W-1:0]    sub;

   assign up_ready = !valid_ff || dn_ready;

   always_comb begin
      for (int j = 0; j < hcd_pkg::ROOT_LANES; j++) begin
         // bring down the next two radicand bits
         trial[j]  = {up_rem[j], up_rad[j][RAD_W-1 -: 2]};
         sub[j]    = TR_W'({up_root[j], 2'b01});
         rad_in[j] = up_rad[j] << 2;
         if (trial[j] >= sub[j]) begin
            rem_in[j]  = REM_W'(trial[j] - sub[j]);
            root_in[j] = {up_root[j][ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[j]  = REM_W'(trial[j]);
            root_in[j] = {up_root[j][ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= up_side;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rad   = rad_ff;
   assign dn_rem   = rem_ff;
   assign dn_root  = root_ff;
   assign dn_side  = side_ff;

endmodule

// ----- src/hcd_div_cell.sv -----
// One quotient bit of the three-lane restoring divider chain.
`timescale 1ns / 1ps

module hcd_div_cell #(
   parameter int NUM_W = 19,
   parameter int DIV_W = 13,
   parameter int BIT   = 7
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         up_valid,
   output logic                                         up_ready,
   input  logic [hcd_pkg::DIV_LANES-1:0][NUM_W-1:0]     up_rem,
   input  logic [hcd_pkg::DIV_LANES-1:0][DIV_W-1:0]     up_div,
   input  logic [hcd_pkg::DIV_LANES-1:0][hcd_pkg::QUO_W-1:0] up_quo,
   output logic                                         dn_valid,
   input  logic                                         dn_ready,
   output logic [hcd_pkg::DIV_LANES-1:0][NUM_W-1:0]     dn_rem,
   output logic [hcd_pkg::DIV_LANES-1:0][DIV_W-1:0]     dn_div,
   output logic [hcd_pkg::DIV_LANES-1:0][hcd_pkg::QUO_W-1:0] dn_quo
);

   localparam int CMP_W = NUM_W + hcd_pkg::QUO_W;

   logic                                                    valid_ff;
   logic [hcd_pkg::DIV_LANES-1:0][NUM_W-1:0]                rem_ff, rem_in;
   logic [hcd_pkg::DIV_LANES-1:0][DIV_W-1:0]                div_ff;
   logic [hcd_pkg::DIV_LANES-1:0][hcd_pkg::QUO_W-1:0]       quo_ff, quo_in;
   logic [hcd_pkg::DIV_LANES-1:0][CMP_W-1:0]                shifted;
   logic [hcd_pkg::DIV_LANES-1:0]                           fits;

   assign up_ready = !valid_ff || dn_ready;

   always_comb begin
      for (int j = 0; j < hcd_pkg::DIV_LANES; j++) begin
         shifted[j] = CMP_W'(up_div[j]) << BIT;
         fits[j]    = CMP_W'(up_rem[j]) >= shifted[j];
         rem_in[j]  = fits[j] ? NUM_W'(CMP_W'(up_rem[j]) - shifted[j]) : up_rem[j];
         quo_in[j]  = up_quo[j];
         quo_in[j][BIT] = fits[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         rem_ff <= rem_in;
         div_ff <= up_div;
         quo_ff <= quo_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rem   = rem_ff;
   assign dn_div   = div_ff;
   assign dn_quo   = quo_ff;

endmodule

// ----- tb/sv/tb_haptic_compass_drive.sv -----
// Testbench for haptic_compass_drive: directed table plus random samples against a predictor.
`timescale 1ns / 1ps

module tb_haptic_compass_drive;

   localparam int SAMPLE_BITS  = 12;
   localparam int LATENCY      = SAMPLE_BITS + 11;
   localparam int DRAIN_CYCLES = LATENCY + 8;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_ITEMS  = 135;

   // Indexes past the last register; writes there must be ignored
   localparam logic [hcd_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_LO = 2'd2;
   localparam logic [hcd_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_HI = 2'd3;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] x;
      logic signed [SAMPLE_BITS-1:0] y;
      logic signed [SAMPLE_BITS-1:0] z;
   } sample_type;

   typedef struct packed {
      logic [hcd_pkg::QUO_W-1:0] period_ms;
      logic [hcd_pkg::QUO_W-1:0] duty_y;
      logic [hcd_pkg::QUO_W-1:0] duty_z;
   } drive_type;

   typedef enum logic [1:0] {ROW_SILENT, ROW_TYPED, ROW_PREDICT} row_kind_type;
   typedef enum logic [1:0] {SPAN_FULL, SPAN_NEAR, SPAN_ZERO} span_type;

   typedef struct packed {
      row_kind_type kind;
      sample_type   s;
      drive_type    want;
   } table_row_type;

   localparam int DIRECTED_N = 23;

   // Typed rows assume the reset register values
   table_row_type directed_rows [DIRECTED_N] = '{
      '{ROW_SILENT,  '{12'sd0, 12'sd0, 12'sd0},          '{8'd0, 8'd0, 8'd0}},
      '{ROW_TYPED,   '{12'sd1, 12'sd0, 12'sd0},          '{8'd255, 8'd0, 8'd0}},
      '{ROW_TYPED,   '{12'sd0, 12'sd1, 12'sd0},          '{8'd255, 8'd240, 8'd0}},
      '{ROW_TYPED,   '{12'sd0, 12'sd0, 12'sd1},          '{8'd255, 8'd0, 8'd240}},
      '{ROW_TYPED,   '{12'sd0, -12'sd1, 12'sd0},         '{8'd255, 8'd0, 8'd0}},
      '{ROW_TYPED,   '{12'sd0, 12'sd0, -12'sd1},         '{8'd255, 8'd0, 8'd0}},
      '{ROW_TYPED,   '{12'sh800, 12'sh800, 12'sh800},    '{8'd4, 8'd0, 8'd0}},
      '{ROW_TYPED,   '{12'sd2047, 12'sd2047, 12'sd2047}, '{8'd4, 8'd169, 8'd169}},
      '{ROW_TYPED,   '{12'sd2047, 12'sd0, 12'sd0},       '{8'd7, 8'd0, 8'd0}},
      '{ROW_TYPED,   '{12'sh800, 12'sd0, 12'sd0},        '{8'd7, 8'd0, 8'd0}},
      '{ROW_TYPED,   '{12'sd0, 12'sd2047, 12'sd0},       '{8'd7, 8'd240, 8'd0}},
      '{ROW_TYPED,   '{12'sd0, 12'sd0, 12'sh800},        '{8'd7, 8'd0, 8'd0}},
      '{ROW_TYPED,   '{12'sd100, 12'sd0, 12'sd0},        '{8'd148, 8'd0, 8'd0}},
      '{ROW_SILENT,  '{12'sd0, 12'sd0, 12'sd0},          '{8'd0, 8'd0, 8'd0}},
      '{ROW_PREDICT, '{12'sd3, 12'sd4, 12'sd0},          '{8'd0, 8'd0, 8'd0}},
      '{ROW_PREDICT, '{12'sd5, -12'sd3, 12'sd4},         '{8'd0, 8'd0, 8'd0}},
      '{ROW_PREDICT, '{-12'sd7, 12'sd12, -12'sd9},       '{8'd0, 8'd0, 8'd0}},
      '{ROW_PREDICT, '{12'sd1000, -12'sd500, 12'sd250},  '{8'd0, 8'd0, 8'd0}},
      '{ROW_PREDICT, '{12'sd0, 12'sd1, 12'sd1},          '{8'd0, 8'd0, 8'd0}},
      '{ROW_PREDICT, '{-12'sd1, -12'sd1, 12'sd1},        '{8'd0, 8'd0, 8'd0}},
      '{ROW_PREDICT, '{12'sd0, 12'sd2047, 12'sh800},     '{8'd0, 8'd0, 8'd0}},
      '{ROW_PREDICT, '{12'sh800, 12'sd2047, 12'sd1},     '{8'd0, 8'd0, 8'd0}},
      '{ROW_PREDICT, '{12'sd12, -12'sd5, 12'sd0},        '{8'd0, 8'd0, 8'd0}}
   };

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic signed [SAMPLE_BITS-1:0]      req_mag_x = '0;
   logic signed [SAMPLE_BITS-1:0]      req_mag_y = '0;
   logic signed [SAMPLE_BITS-1:0]      req_mag_z = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic [hcd_pkg::QUO_W-1:0]          rsp_period_ms;
   logic [hcd_pkg::QUO_W-1:0]          rsp_duty_y;
   logic [hcd_pkg::QUO_W-1:0]          rsp_duty_z;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [hcd_pkg::CSR_INDEX_W-1:0]    csr_index = '0;
   logic [hcd_pkg::CSR_DATA_W-1:0]     csr_data = '0;

   logic [hcd_pkg::BASE_W-1:0] base_model = hcd_pkg::BASE_STRENGTH_RESET;
   logic [hcd_pkg::DUTY_W-1:0] duty_model = hcd_pkg::FULL_DUTY_RESET;

   drive_type expected_drive [$];
   int        mismatch_count = 0;
   int        cycle_count = 0;
   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;
   int        hold_requests = 0;
   int        hold_served = 0;
   int        hold_left = 0;

   haptic_compass_drive #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mag_x     (req_mag_x),
      .req_mag_y     (req_mag_y),
      .req_mag_z     (req_mag_z),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_period_ms (rsp_period_ms),
      .rsp_duty_y    (rsp_duty_y),
      .rsp_duty_z    (rsp_duty_z),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic flag_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   function automatic int unsigned floor_root(input int unsigned n);
      int unsigned rem, root, probe;
      rem = n;
      root = 0;
      probe = 32'h4000_0000;
      while (probe > rem)
         probe >>= 2;
      while (probe != 0) begin
         if (rem >= root + probe) begin
            rem -= root + probe;
            root = (root >> 1) + probe;
         end else begin
            root >>= 1;
         end
         probe >>= 2;
      end
      return root;
   endfunction

   function automatic logic [hcd_pkg::QUO_W-1:0] axis_duty(input int c,
                                                           input int unsigned mag);
      int unsigned q;
      if (c <= 0 || mag == 0)
         return '0;
      q = int'(duty_model) * c / mag;
      if (q > int'(duty_model))
         q = int'(duty_model);
      return hcd_pkg::QUO_W'(q);
   endfunction

   // Returns 0 for an all-zero sample, which produces no result
   function automatic bit compute_drive(input sample_type s, output drive_type d);
      int          x, y, z;
      int unsigned root_all, root_yz, period;
      x = int'(s.x);
      y = int'(s.y);
      z = int'(s.z);
      d = '0;
      if (x == 0 && y == 0 && z == 0)
         return 1'b0;
      root_yz = floor_root(y * y + z * z);
      root_all = floor_root(x * x + y * y + z * z);
      period = int'(base_model) / (root_all + 1);
      if (period > 255)
         period = 255;
      d.period_ms = hcd_pkg::QUO_W'(period);
      d.duty_y = axis_duty(y, root_yz);
      d.duty_z = axis_duty(z, root_yz);
      return 1'b1;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] rand_component(input span_type span);
      case (span)
         SPAN_FULL: return SAMPLE_BITS'($urandom);
         SPAN_NEAR: return SAMPLE_BITS'(int'($urandom_range(127)) - 64);
         default:   return '0;
      endcase
   endfunction

   function automatic sample_type random_sample();
      sample_type  s;
      int unsigned pick;
      span_type    span [3];
      pick = $urandom_range(15);
      if (pick == 0)
         return '0;
      for (int i = 0; i < 3; i++) begin
         if (pick < 7)
            span[i] = SPAN_FULL;
         else if (pick < 13)
            span[i] = SPAN_NEAR;
         else
            span[i] = $urandom_range(1) ? SPAN_ZERO : SPAN_FULL;
      end
      s.x = rand_component(span[0]);
      s.y = rand_component(span[1]);
      s.z = rand_component(span[2]);
      return s;
   endfunction

   // Entered at a rising edge; returns at the edge of the transfer
   task automatic send_sample(input sample_type s, input row_kind_type kind,
                              input drive_type want);
      drive_type d;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mag_x <= s.x;
      req_mag_y <= s.y;
      req_mag_z <= s.z;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      case (kind)
         ROW_TYPED:   expected_drive.push_back(want);
         ROW_PREDICT: if (compute_drive(s, d)) expected_drive.push_back(d);
         default:     ;
      endcase
   endtask

   task automatic write_reg(input logic [hcd_pkg::CSR_INDEX_W-1:0] index,
                            input logic [hcd_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      if (index == hcd_pkg::CSR_BASE_STRENGTH)
         base_model = data;
      else if (index == hcd_pkg::CSR_FULL_DUTY)
         duty_model = data[hcd_pkg::DUTY_W-1:0];
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Wait out every pending result, then cover dropped samples still in flight
   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (expected_drive.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_random(input int count);
      for (int i = 0; i < count; i++)
         send_sample(random_sample(), ROW_PREDICT, '0);
   endtask

   task automatic set_idle(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct <= recv_pct;
   endtask

   // Receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         rsp_ready <= 1'b0;
         hold_served <= hold_served + 1;
         hold_left <= HOLD_CYCLES;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Check each result transfer against the oldest expectation
   always @(negedge clock) begin
      drive_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_drive.size() == 0) begin
            flag_mismatch($sformatf("result %0d/%0d/%0d with nothing expected",
                                    rsp_period_ms, rsp_duty_y, rsp_duty_z));
         end else begin
            want = expected_drive.pop_front();
            if (rsp_period_ms !== want.period_ms)
               flag_mismatch($sformatf("period_ms got %0d want %0d",
                                       rsp_period_ms, want.period_ms));
            if (rsp_duty_y !== want.duty_y)
               flag_mismatch($sformatf("duty_y got %0d want %0d", rsp_duty_y, want.duty_y));
            if (rsp_duty_z !== want.duty_z)
               flag_mismatch($sformatf("duty_z got %0d want %0d", rsp_duty_z, want.duty_z));
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idle(10, 49);
      for (int i = 0; i < DIRECTED_N; i++)
         send_sample(directed_rows[i].s, directed_rows[i].kind, directed_rows[i].want);
      drain_pipe();

      write_reg(hcd_pkg::CSR_BASE_STRENGTH, 16'hFFFF);
      write_reg(hcd_pkg::CSR_FULL_DUTY, 16'h00FF);
      write_reg(CSR_UNUSED_LO, hcd_pkg::CSR_DATA_W'($urandom));
      run_random(PHASE_ITEMS);
      drain_pipe();

      set_idle(49, 10);
      write_reg(hcd_pkg::CSR_BASE_STRENGTH, 16'h0000);
      write_reg(hcd_pkg::CSR_FULL_DUTY, 16'hFF00);
      run_random(PHASE_ITEMS);
      drain_pipe();

      write_reg(hcd_pkg::CSR_BASE_STRENGTH, hcd_pkg::CSR_DATA_W'($urandom));
      write_reg(hcd_pkg::CSR_FULL_DUTY, hcd_pkg::CSR_DATA_W'($urandom));
      write_reg(CSR_UNUSED_HI, hcd_pkg::CSR_DATA_W'($urandom));
      run_random(PHASE_ITEMS);
      drain_pipe();

      // Hold the receiver off while samples keep coming so the pipe backs up
      set_idle(0, 0);
      write_reg(hcd_pkg::CSR_BASE_STRENGTH, hcd_pkg::CSR_DATA_W'($urandom_range(4095)));
      write_reg(hcd_pkg::CSR_FULL_DUTY, hcd_pkg::CSR_DATA_W'($urandom_range(255)));
      hold_requests <= hold_requests + 1;
      run_random(PHASE_ITEMS);
      drain_pipe();

      write_reg(hcd_pkg::CSR_BASE_STRENGTH, hcd_pkg::BASE_STRENGTH_RESET);
      write_reg(hcd_pkg::CSR_FULL_DUTY, {8'($urandom), hcd_pkg::FULL_DUTY_RESET});
      run_random(PHASE_ITEMS);
      drain_pipe();

      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
